[hw/rtl/crc32_record_checker_core_assert.svh]
// Assertion macros shared by the record checker RTL.
// Each macro takes a label, a clock, an active-low reset, an antecedent and a consequent.
`ifndef CRC32_RECORD_CHECKER_CORE_ASSERT_SVH
`define CRC32_RECORD_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication: when the antecedent holds, so must the consequent.
`define CRC32RC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("crc32rc assertion failed");

// Next-cycle implication: the consequent is checked after the antecedent holds.
`define CRC32RC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("crc32rc assertion failed");

`endif

[hw/rtl/crc32rc_pkg.sv]
// Package for the CRC-32 record checker: constants, register map and config type.
// It has no dependencies. All record checker modules import it.
package crc32rc_pkg;

    // Reflected CRC-32 constants.
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Record framing constants.
    localparam logic [7:0] TRAILER_BYTES  = 8'd4;
    localparam logic [7:0] MIN_RECORD_LEN = 8'd5;
    localparam logic [7:0] COUNT_MAX      = 8'd255;

    // APB register map: register i sits at byte address 4*i.
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [0:0] {
        REG_EXPECTED_VERSION = 1'b0,
        REG_RECORD_LENGTH    = 1'b1
    } reg_index_t;

    // Reset values of the configuration registers.
    localparam logic [7:0] EXPECTED_VERSION_RST = 8'd2;
    localparam logic [7:0] RECORD_LENGTH_RST    = 8'd24;

    // Configuration handed from the register block to the datapath.
    typedef struct packed {
        logic [7:0] expected_version;
        logic [7:0] record_length;
    } cfg_t;

endpackage

[hw/rtl/crc32rc_crc8.sv]
// Byte-wide unrolled update of a reflected CRC-32 register.
// Depends on crc32rc_pkg for the polynomial.
module crc32rc_crc8 (
    input  logic [31:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [31:0] crc_out
);
    import crc32rc_pkg::*;

    // Fold the byte in, then shift eight times, one bit per step.
    always_comb begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data_in};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        crc_out = c;
    end

endmodule

[hw/rtl/crc32rc_regs.sv]
// APB configuration registers of the record checker: expected version and length.
// Depends on crc32rc_pkg for the register map, reset values and cfg_t.
module crc32rc_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [crc32rc_pkg::ADDR_W-1:0]      paddr,
    input  logic [crc32rc_pkg::DATA_W-1:0]      pwdata,
    output logic [crc32rc_pkg::DATA_W-1:0]      prdata,
    output logic                                pready,
    output crc32rc_pkg::cfg_t                   cfg
);
    import crc32rc_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t reg_index;
    logic       write_en;

    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[2]);
    assign write_en  = psel && penable && pwrite && pready;

    // Register writes complete in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_version <= EXPECTED_VERSION_RST;
            cfg_reg.record_length    <= RECORD_LENGTH_RST;
        end else if (write_en) begin
            unique case (reg_index)
                REG_EXPECTED_VERSION: cfg_reg.expected_version <= pwdata[7:0];
                REG_RECORD_LENGTH:    cfg_reg.record_length    <= pwdata[7:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read data is the addressed register, zero extended.
    always_comb begin
        unique case (reg_index)
            REG_EXPECTED_VERSION: prdata = {{(DATA_W-8){1'b0}}, cfg_reg.expected_version};
            REG_RECORD_LENGTH:    prdata = {{(DATA_W-8){1'b0}}, cfg_reg.record_length};
            default:              prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/crc32_record_checker_core.sv]
// Top level of the CRC-32 record checker: record state, result register and handshakes.
// Depends on crc32rc_pkg, crc32rc_regs, crc32rc_crc8 and the assertion macro header.
//
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_data_byte, s_last_byte
// m_        out        m_valid / m_ready  m_record_ok, m_version_match, m_checksum_match,
//                                         m_length_match, m_computed_crc
// APB       in         psel / penable     paddr, pwdata, prdata (pready always high)
//
// One item per cycle while s_ready is high: each byte updates the record state when it is accepted.
// The result of a last byte is registered and appears in the output register in the cycle after acceptance.
// The critical path is the byte-wide CRC update followed by the 32-bit trailer compare.
// Reset is synchronous and active low; it clears the record state and the result valid.
// s_ready is low only while a result waits and m_ready is low.
`include "crc32_record_checker_core_assert.svh"

module crc32_record_checker_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Byte input channel.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_data_byte,
    input  logic                                s_last_byte,
    // Result channel.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_record_ok,
    output logic                                m_version_match,
    output logic                                m_checksum_match,
    output logic                                m_length_match,
    output logic [31:0]                         m_computed_crc,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [crc32rc_pkg::ADDR_W-1:0]      paddr,
    input  logic [crc32rc_pkg::DATA_W-1:0]      pwdata,
    output logic [crc32rc_pkg::DATA_W-1:0]      prdata,
    output logic                                pready
);
    import crc32rc_pkg::*;

    cfg_t        cfg;

    // Record state.
    logic [31:0] crc_reg;
    logic [7:0]  byte_count_reg;
    logic [31:0] trailer_reg;
    logic        version_ok_reg;
    logic        overlong_reg;

    // Result register.
    logic        m_valid_reg;
    logic        record_ok_reg;
    logic        version_match_reg;
    logic        checksum_match_reg;
    logic        length_match_reg;
    logic [31:0] computed_crc_reg;

    // Per-byte next values.
    logic        accept;
    logic        first_byte;
    logic        crc_enable;
    logic [31:0] crc_stepped;
    logic [31:0] crc_next;
    logic [31:0] trailer_next;
    logic [7:0]  byte_count_next;
    logic        overlong_next;
    logic        version_ok_next;
    logic [31:0] computed_crc_next;
    logic        checksum_match_next;
    logic        length_match_next;

    crc32rc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The byte leaving the four-byte trailer window is the one folded into the CRC.
    crc32rc_crc8 u_crc8 (
        .crc_in  (crc_reg),
        .data_in (trailer_reg[7:0]),
        .crc_out (crc_stepped)
    );

    // A new item is taken unless a finished result is still waiting and m_ready is low.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Next record state for the byte on the input.
    always_comb begin
        first_byte      = (byte_count_reg == 8'd0) && !overlong_reg;
        version_ok_next = first_byte ? (s_data_byte == cfg.expected_version)
                                     : version_ok_reg;
        crc_enable      = (byte_count_reg >= TRAILER_BYTES) || overlong_reg;
        crc_next        = crc_enable ? crc_stepped : crc_reg;
        trailer_next    = {s_data_byte, trailer_reg[31:8]};
        overlong_next   = overlong_reg || (byte_count_reg == COUNT_MAX);
        byte_count_next = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                        : byte_count_reg + 8'd1;
    end

    // Result fields, meaningful when the byte is the last of its record.
    always_comb begin
        computed_crc_next   = ~crc_next;
        checksum_match_next = (trailer_next == computed_crc_next);
        length_match_next   = !overlong_next && (cfg.record_length >= MIN_RECORD_LEN)
                              && (byte_count_next == cfg.record_length);
    end

    // Record state: advance on each item, clear after the last byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg        <= CRC_INIT;
            byte_count_reg <= 8'd0;
            trailer_reg    <= 32'd0;
            version_ok_reg <= 1'b0;
            overlong_reg   <= 1'b0;
        end else if (accept) begin
            if (s_last_byte) begin
                crc_reg        <= CRC_INIT;
                byte_count_reg <= 8'd0;
                trailer_reg    <= 32'd0;
                version_ok_reg <= 1'b0;
                overlong_reg   <= 1'b0;
            end else begin
                crc_reg        <= crc_next;
                byte_count_reg <= byte_count_next;
                trailer_reg    <= trailer_next;
                version_ok_reg <= version_ok_next;
                overlong_reg   <= overlong_next;
            end
        end
    end

    // Result valid: set by an accepted last byte, cleared when the result is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && s_last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded with the valid bit.
    always_ff @(posedge aclk) begin
        if (accept && s_last_byte) begin
            record_ok_reg      <= version_ok_next && checksum_match_next && length_match_next;
            version_match_reg  <= version_ok_next;
            checksum_match_reg <= checksum_match_next;
            length_match_reg   <= length_match_next;
            computed_crc_reg   <= computed_crc_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_record_ok      = record_ok_reg;
    assign m_version_match  = version_match_reg;
    assign m_checksum_match = checksum_match_reg;
    assign m_length_match   = length_match_reg;
    assign m_computed_crc   = computed_crc_reg;

    // Checks on the record state and the result register.
    `CRC32RC_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, accept && s_last_byte, (byte_count_reg == 8'd0) && !overlong_reg && (crc_reg == CRC_INIT) && (trailer_reg == 32'd0))
    `CRC32RC_ASSERT_NEXT(a_result_after_last, aclk, aresetn, accept && s_last_byte, m_valid_reg)
    `CRC32RC_ASSERT_SAME(a_overlong_saturated, aclk, aresetn, overlong_reg, byte_count_reg == COUNT_MAX)
    `CRC32RC_ASSERT_SAME(a_ok_is_and, aclk, aresetn, m_valid_reg, record_ok_reg == (version_match_reg && checksum_match_reg && length_match_reg))

endmodule
